// ===== hw/rtl/shtab_pkg.sv =====
// ----------------------------------------------------------------------------
// shtab_pkg
// Shared constants, types and lookup tables for the symbol hash table insert.
// ----------------------------------------------------------------------------
package shtab_pkg;

  localparam int unsigned TABLE_DEPTH = 256;  // power of two
  localparam int unsigned NAME_LEN    = 32;

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned LEN_W  = $clog2(NAME_LEN + 1);
  localparam int unsigned S3_W   = $clog2(2 * NAME_LEN + 1);
  localparam int unsigned S5_W   = $clog2(4 * NAME_LEN + 1);
  localparam int unsigned S7_W   = $clog2(6 * NAME_LEN + 1);
  localparam int unsigned SB_W   = $clog2(255 * NAME_LEN + 1);

  localparam logic [7:0] EXTERNAL_CODE = 8'd64;  // '@'
  localparam logic [7:0] NUL_CHAR      = 8'd0;

  typedef enum logic [1:0] {
    KIND_EMPTY    = 2'd0,
    KIND_EXTERNAL = 2'd1,
    KIND_DEFINED  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  section;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              ext;
    logic [7:0]        section;
    logic [31:0]       offset;
  } ins_req_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] slot;
  } ins_res_t;

  // byte residue tables, built by counting so no divider is involved
  typedef logic [2:0] mod_lut_t [256];

  function automatic mod_lut_t gen_mod_lut(input int unsigned m);
    mod_lut_t    lut;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 3'(r);
      if (r == m - 1) r = 0;
      else r = r + 1;
    end
    return lut;
  endfunction

  localparam mod_lut_t MOD3_LUT = gen_mod_lut(3);
  localparam mod_lut_t MOD5_LUT = gen_mod_lut(5);
  localparam mod_lut_t MOD7_LUT = gen_mod_lut(7);

endpackage

// ===== hw/rtl/shtab_accum.sv =====
// ----------------------------------------------------------------------------
// shtab_accum
// Running name sums and the slot hash for the byte being transferred.
// ----------------------------------------------------------------------------
module shtab_accum
  import shtab_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        name_char_i,
  input  logic              is_last_i,
  output logic [SLOT_W-1:0] slot_o
);

  logic [S3_W-1:0]  s3_q, s3_d, s3_n;
  logic [S5_W-1:0]  s5_q, s5_d, s5_n;
  logic [S7_W-1:0]  s7_q, s7_d, s7_n;
  logic [SB_W-1:0]  sb_q, sb_d, sb_n;
  logic [LEN_W-1:0] len_q, len_d, len_n;
  logic             ended_q, ended_d, ended_n;
  logic             open_name;
  logic [31:0]      hash;

  assign open_name = !ended_q && (len_q < LEN_W'(NAME_LEN));

  always_comb begin
    s3_n    = s3_q;
    s5_n    = s5_q;
    s7_n    = s7_q;
    sb_n    = sb_q;
    len_n   = len_q;
    ended_n = ended_q;
    if (open_name) begin
      if (name_char_i == NUL_CHAR) begin
        ended_n = 1'b1;
      end else begin
        s3_n  = s3_q + S3_W'(MOD3_LUT[name_char_i]);
        s5_n  = s5_q + S5_W'(MOD5_LUT[name_char_i]);
        s7_n  = s7_q + S7_W'(MOD7_LUT[name_char_i]);
        sb_n  = sb_q + SB_W'(name_char_i);
        len_n = len_q + LEN_W'(1);
      end
    end

    // 32-bit wrapping hash, slot is its low bits
    hash = (32'(len_n) << 24) + (32'(sb_n) << 16) + (32'(s7_n) << 8)
         + (32'(s5_n) << 4) + 32'(s3_n);
    slot_o = hash[SLOT_W-1:0];

    if (is_last_i) begin
      s3_d    = '0;
      s5_d    = '0;
      s7_d    = '0;
      sb_d    = '0;
      len_d   = '0;
      ended_d = 1'b0;
    end else begin
      s3_d    = s3_n;
      s5_d    = s5_n;
      s7_d    = s7_n;
      sb_d    = sb_n;
      len_d   = len_n;
      ended_d = ended_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q    <= '0;
      s5_q    <= '0;
      s7_q    <= '0;
      sb_q    <= '0;
      len_q   <= '0;
      ended_q <= 1'b0;
    end else if (fire_i) begin
      s3_q    <= s3_d;
      s5_q    <= s5_d;
      s7_q    <= s7_d;
      sb_q    <= sb_d;
      len_q   <= len_d;
      ended_q <= ended_d;
    end
  end

endmodule

// ===== hw/rtl/shtab_table.sv =====
// ----------------------------------------------------------------------------
// shtab_table
// Entry store with per-slot valid bits, insert decision and write-back.
// ----------------------------------------------------------------------------
module shtab_table
  import shtab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_fire_i,
  input  ins_req_t req_i,
  input  logic     adv_i,
  output logic     res_valid_o,
  output ins_res_t res_o
);

  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;

  logic     p1_vld_q;
  ins_req_t p1_q;
  entry_t   rd_q;
  logic     fwd_q;
  kind_e    fwd_kind_q;

  kind_e    kind_cur;
  kind_e    kind_new;
  logic     ok;
  logic     wr_en;

  always_comb begin
    // a write at the same edge as the read is not in rd_q yet
    if (fwd_q) kind_cur = fwd_kind_q;
    else if (vld_q[p1_q.slot]) kind_cur = rd_q.kind;
    else kind_cur = KIND_EMPTY;

    if (p1_q.ext) ok = (kind_cur == KIND_EMPTY);
    else ok = (kind_cur == KIND_EMPTY) || (kind_cur == KIND_EXTERNAL);

    kind_new = p1_q.ext ? KIND_EXTERNAL : KIND_DEFINED;
    wr_en    = p1_vld_q && adv_i && ok;
  end

  assign res_valid_o    = p1_vld_q;
  assign res_o.accepted = ok;
  assign res_o.slot     = 8'(p1_q.slot);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[p1_q.slot] <= '{kind: kind_new, section: p1_q.section, offset: p1_q.offset};
    end
    if (req_fire_i) begin
      rd_q       <= mem[req_i.slot];
      p1_q       <= req_i;
      fwd_kind_q <= kind_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      p1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[p1_q.slot] <= 1'b1;
      end
      if (req_fire_i) begin
        p1_vld_q <= 1'b1;
        fwd_q    <= wr_en && (p1_q.slot == req_i.slot);
      end else if (adv_i) begin
        p1_vld_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/symbol_hash_table_insert.sv =====
// ----------------------------------------------------------------------------
// symbol_hash_table_insert
// Streams symbol names byte by byte and inserts each name into a hash table.
// ----------------------------------------------------------------------------
// Input stream: one name byte per transfer with its section and offset;
// tlast marks the final byte of a name, where the insert is attempted.
// Sums stop at a zero byte or after NAME_LEN bytes; later bytes are ignored.
// Output stream: one transfer per name, carrying the accepted flag and slot.
// Non-last bytes produce no output.
// Path: a last byte's result moves through the decision stage register and
// then the output register before m_axis_tvalid rises.
// Throughput: one byte per cycle unless stalled; the table read is issued at
// the input edge and the write-back lands as the result moves to the output
// register, a forwarding register covering back-to-back inserts to the same slot.
// Reset clears the name sums and all slot valid bits (every slot empty).
// When the receiver stalls, the output register holds, one more name waits
// in the decision stage, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module symbol_hash_table_insert
  import shtab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // name_char[7:0], section[15:8], offset[47:16]
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // accepted[0], slot[8:1], zero[15:9]
);

  logic              fire;
  logic              adv;
  logic [SLOT_W-1:0] slot;
  ins_req_t          req;
  logic              res_valid;
  ins_res_t          res;
  logic              out_vld_q;
  ins_res_t          out_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !res_valid || adv;
  assign fire          = s_axis_tvalid && s_axis_tready;

  shtab_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .name_char_i (s_axis_tdata[7:0]),
    .is_last_i   (s_axis_tlast),
    .slot_o      (slot)
  );

  assign req.slot    = slot;
  assign req.ext     = (s_axis_tdata[15:8] == EXTERNAL_CODE);
  assign req.section = s_axis_tdata[15:8];
  assign req.offset  = s_axis_tdata[47:16];

  shtab_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_fire_i  (fire && s_axis_tlast),
    .req_i       (req),
    .adv_i       (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.slot, out_q.accepted};

endmodule

// ===== hw/rtl/shtab_checker.sv =====
// ----------------------------------------------------------------------------
// shtab_checker
// Port-level checks for symbol_hash_table_insert, bound to the top level.
// ----------------------------------------------------------------------------
module shtab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // input only backs up when the output is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input not ready without output stall");

  // a fresh result follows a last-byte transfer through the decision and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid)
      |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a preceding last-byte transfer");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("nonzero pad bits in output");

endmodule

bind symbol_hash_table_insert shtab_checker u_shtab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
